FILE: rtl/core/mmn_pkg.sv
`timescale 1ns / 1ps

package mmn_pkg;

    // Result word: signed, 16 fraction bits, 24 bits in all.
    localparam int FRAC_BITS  = 16;
    localparam int OUT_BITS   = 24;
    // Bits of the dividend above the fraction bits that the divider walks through.
    localparam int UNIT_SHIFT = OUT_BITS - FRAC_BITS;
    // One unit in Q8.8, the range that stands in for a flat measurement.
    localparam int ONE_UNIT   = 256;
    localparam int CNT_BITS   = 5;

    localparam logic [15:0] FLAT_LIMIT_RESET = 16'd1;

    localparam logic OP_MEASURE   = 1'b0;
    localparam logic OP_NORMALIZE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RANGE,
        ST_PREP,
        ST_START,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

FILE: rtl/core/mmn_if.sv
`timescale 1ns / 1ps

interface mmn_in_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          first;

    modport source (output valid, op, sample, first, input ready);
    modport sink   (input valid, op, sample, first, output ready);
endinterface

interface mmn_out_if import mmn_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] normalized;
    logic                       flat;

    modport source (output valid, normalized, flat, input ready);
    modport sink   (input valid, normalized, flat, output ready);
endinterface

FILE: rtl/core/mmn_div.sv
`timescale 1ns / 1ps

module mmn_div import mmn_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [SAMPLE_BITS:0]  i_mag,
    input  logic [SAMPLE_BITS:0]  i_den,
    output logic                  o_done,
    output logic                  o_sat,
    output logic [OUT_BITS-1:0]   o_quot
);

    localparam int RW = SAMPLE_BITS + 1;
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(OUT_BITS - 1);

    logic                r_busy;
    logic                r_done;
    logic                r_sat;
    logic [CNT_BITS-1:0] r_cnt;
    logic [RW-1:0]       r_rem;
    logic [RW-1:0]       r_den;
    logic [OUT_BITS-1:0] r_dvd;
    logic [OUT_BITS-1:0] r_quot;

    logic                w_big;
    logic [RW:0]         w_trial;
    logic [RW:0]         w_diff;

    // A quotient of 2^24 or more saturates whatever its low bits are, so it
    // is caught up front and the remaining quotient fits in 24 bits.
    assign w_big   = {{UNIT_SHIFT{1'b0}}, i_mag} >= {i_den, {UNIT_SHIFT{1'b0}}};
    assign w_trial = {r_rem, r_dvd[OUT_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= !w_big;
            r_done <= w_big;
        end else if (r_busy) begin
            r_busy <= (r_cnt != CNT_LAST);
            r_done <= (r_cnt == CNT_LAST);
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sat  <= w_big;
            r_cnt  <= '0;
            r_den  <= i_den;
            r_rem  <= i_mag >> UNIT_SHIFT;
            r_dvd  <= {i_mag[UNIT_SHIFT-1:0], {FRAC_BITS{1'b0}}};
            r_quot <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_dvd <= {r_dvd[OUT_BITS-2:0], 1'b0};
            if (!w_diff[RW]) begin
                r_rem  <= w_diff[RW-1:0];
                r_quot <= {r_quot[OUT_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= w_trial[RW-1:0];
                r_quot <= {r_quot[OUT_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_sat  = r_sat;
    assign o_quot = r_quot;

endmodule

FILE: rtl/core/min_max_normalizer_core.sv
`timescale 1ns / 1ps
// Measure words are taken one per cycle while the core is idle and give no result.
// A normalize word passes the setup states RANGE, PREP and START and then a 24-bit restoring
// divider, one quotient bit per cycle; the next word can be taken in the cycle that its result
// is shown on the output. A saturating quotient skips the divider's quotient bits.
// Synchronous active-low reset: min and max return to their extremes, flat_limit to 1.

module min_max_normalizer_core import mmn_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    mmn_in_if.sink      i_in,
    mmn_out_if.source   o_out
);

    localparam int RW = SAMPLE_BITS + 1;
    localparam int CW = (RW > 17) ? RW : 17;
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAXV = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MINV = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [OUT_BITS-1:0] POS_SAT = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic [OUT_BITS-1:0] NEG_SAT = {1'b1, {(OUT_BITS-1){1'b0}}};

    t_state r_state;
    t_state n_state;

    logic [15:0]                   r_flat_limit;
    logic signed [SAMPLE_BITS-1:0] r_min;
    logic signed [SAMPLE_BITS-1:0] r_max;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic signed [RW-1:0]          r_range;
    logic                          r_flat;
    logic                          r_neg;
    logic [RW-1:0]                 r_mag;
    logic [RW-1:0]                 r_den;
    logic                          r_out_valid;
    logic [OUT_BITS-1:0]           r_out_norm;
    logic                          r_out_flat;

    logic                          w_accept;
    logic                          w_start;
    logic                          w_load;
    logic signed [SAMPLE_BITS-1:0] w_sample;
    logic signed [RW-1:0]          w_range;
    logic                          w_flat;
    logic signed [SAMPLE_BITS-1:0] w_lo;
    logic signed [RW-1:0]          w_num;
    logic                          w_done;
    logic                          w_sat;
    logic [OUT_BITS-1:0]           w_quot;
    logic [OUT_BITS-1:0]           w_result;

    assign w_sample = i_in.sample;
    assign w_accept = i_in.valid && i_in.ready;
    assign w_start  = (r_state == ST_START);
    assign w_load   = (r_state == ST_OUT) && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        i_in.ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid && i_in.op == OP_NORMALIZE) begin
                    n_state = ST_RANGE;
                end
            end
            ST_RANGE: n_state = ST_PREP;
            ST_PREP:  n_state = ST_START;
            ST_START: n_state = ST_DIV;
            ST_DIV: begin
                if (w_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flat_limit <= FLAT_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_flat_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= SMP_MAXV;
            r_max <= SMP_MINV;
        end else if (w_accept && i_in.op == OP_MEASURE) begin
            if (i_in.first) begin
                r_min <= w_sample;
                r_max <= w_sample;
            end else begin
                if (w_sample < r_min) begin
                    r_min <= w_sample;
                end
                if (w_sample > r_max) begin
                    r_max <= w_sample;
                end
            end
        end
    end

    // A range that is negative (nothing measured yet), zero or below the limit is flat.
    assign w_range = RW'(r_max) - RW'(r_min);
    assign w_flat  = w_range[RW-1] || (w_range == '0) ||
                     (CW'($unsigned(w_range)) < CW'(r_flat_limit));

    assign w_lo  = r_flat ? '0 : r_min;
    assign w_num = RW'(r_sample) - RW'(w_lo);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= w_sample;
        end
        if (r_state == ST_RANGE) begin
            r_range <= w_range;
            r_flat  <= w_flat;
        end
        if (r_state == ST_PREP) begin
            r_neg <= w_num[RW-1];
            r_mag <= w_num[RW-1] ? $unsigned(-w_num) : $unsigned(w_num);
            r_den <= r_flat ? RW'(ONE_UNIT) : $unsigned(r_range);
        end
    end

    mmn_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_mag   (r_mag),
        .i_den   (r_den),
        .o_done  (w_done),
        .o_sat   (w_sat),
        .o_quot  (w_quot)
    );

    // The negative side reaches one step further than the positive side.
    always_comb begin
        if (r_neg) begin
            if (w_sat || (w_quot[OUT_BITS-1] && (|w_quot[OUT_BITS-2:0]))) begin
                w_result = NEG_SAT;
            end else begin
                w_result = '0 - w_quot;
            end
        end else begin
            if (w_sat || w_quot[OUT_BITS-1]) begin
                w_result = POS_SAT;
            end else begin
                w_result = w_quot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_norm <= w_result;
            r_out_flat <= r_flat;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.normalized = r_out_norm;
    assign o_out.flat       = r_out_flat;

endmodule
